// ===== hw/rtl/fdf_pkg.sv =====
// Shared constants, codes and types for the decimating FIR filter core.
package fdf_pkg;

  localparam int MAX_TAPS    = 256;
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 18;

  localparam int IDX_W  = $clog2(MAX_TAPS);
  localparam int CNT_W  = $clog2(MAX_TAPS + 1);
  localparam int SUM_W  = IDX_W + 1;

  localparam int DECIM_W     = 8;
  localparam int TAP_COUNT_W = 9;
  localparam int SCALE_BITS  = 24;
  localparam int COEF_IDX_W  = 8;
  localparam int OUT_BITS    = 32;
  localparam int SHIFT_BITS  = 32;

  localparam int PROD_W   = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W    = SAMPLE_BITS + COEF_BITS + IDX_W;
  localparam int ACC_LO_W = ACC_W / 2;
  localparam int ACC_HI_W = ACC_W - ACC_LO_W;
  localparam int MUL_A_W  = ACC_LO_W + 1;
  localparam int PP_W     = MUL_A_W + SCALE_BITS;
  localparam int SCALED_W = ACC_W + SCALE_BITS;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  localparam logic OP_COEF   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [1:0] REG_DECIMATION = 2'd0;
  localparam logic [1:0] REG_TAP_COUNT  = 2'd1;
  localparam logic [1:0] REG_SCALE      = 2'd2;

  localparam logic [DECIM_W-1:0]     DECIM_RESET = DECIM_W'(32);
  localparam logic [TAP_COUNT_W-1:0] TAPS_RESET  = '0;
  localparam logic [SCALE_BITS-1:0]  SCALE_RESET = SCALE_BITS'(65536);

  localparam logic [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

  typedef struct packed {
    logic clear;
    logic tap_valid;
    logic scale_lo;
    logic scale_hi;
    logic combine;
  } fdf_mac_ctrl_t;

endpackage

// ===== hw/rtl/fir_decimation_filter_core.sv =====
// Decimating FIR filter core: control, register port, tap store, history ring and MAC.
// A sample beat that yields a result starts one full rotation of the history ring, which
// feeds the single MAC; then come MAC drain and scale passes, and the result waits in S_DONE
// until the output is free. The core takes no beat until it is back in S_IDLE.
// Throughput: one beat per cycle between results, while the core is idle.
// Reset clears control, counts and registers; sample ring and tap RAM hold data until written.
module fir_decimation_filter_core import fdf_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [COEF_IDX_W-1:0]         coef_index,
  input  logic signed [COEF_BITS-1:0]   coef_value,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  input  logic                          new_series,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OUT_BITS-1:0]    filtered_value,
  output logic                          saturated,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_ADDR_W-1:0]         paddr,
  input  logic [APB_DATA_W-1:0]         pwdata,
  output logic [APB_DATA_W-1:0]         prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROTATE,
    S_FLUSH1,
    S_FLUSH2,
    S_SCALE_LO,
    S_SCALE_HI,
    S_SUM,
    S_DONE
  } state_t;

  state_t                         state;
  logic [IDX_W-1:0]               step;
  logic [CNT_W-1:0]               fill_count;
  logic [DECIM_W-1:0]             phase;
  logic [DECIM_W-1:0]             decimation;
  logic [TAP_COUNT_W-1:0]         tap_count;
  logic signed [SCALE_BITS-1:0]   scale_factor;

  logic                           in_accept;
  logic                           sample_beat;
  logic [CNT_W-1:0]               taps_eff;
  logic [CNT_W-1:0]               fill_base;
  logic [CNT_W-1:0]               fill_inc;
  logic [DECIM_W-1:0]             phase_base;
  logic [DECIM_W:0]               phase_inc;
  logic [CNT_W-1:0]               fill_next;
  logic [DECIM_W-1:0]             phase_next;
  logic                           emit;
  logic                           go;

  logic [SUM_W-1:0]               tap_sum;
  logic                           tap_valid;
  logic [IDX_W-1:0]               weight_addr;
  logic                           ram_we;
  logic [COEF_BITS-1:0]           weight_raw;
  logic signed [SAMPLE_BITS-1:0]  ring_head;
  fdf_mac_ctrl_t                  mac_ctrl;
  logic signed [SCALED_W-1:0]     scaled;
  logic [SCALED_W-SHIFT_BITS-OUT_BITS:0] top_bits;
  logic                           sat_now;
  logic [OUT_BITS-1:0]            value_now;

  assign in_ready    = (state == S_IDLE);
  assign in_accept   = in_valid & in_ready;
  assign sample_beat = in_accept & (op == OP_SAMPLE);
  assign pready      = 1'b1;

  assign taps_eff = (32'(tap_count) > 32'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : CNT_W'(tap_count);

  always_comb begin
    fill_base  = new_series ? '0 : fill_count;
    phase_base = new_series ? '0 : phase;
    fill_inc   = fill_base + 1'b1;
    phase_inc  = {1'b0, phase_base} + 1'b1;
    fill_next  = fill_base;
    phase_next = phase_base;
    emit       = 1'b0;
    if (fill_base < taps_eff) begin
      fill_next = fill_inc;
      if (fill_inc == taps_eff) begin
        emit       = 1'b1;
        phase_next = '0;
      end
    end else if (taps_eff != '0 && decimation != '0) begin
      if (phase_inc >= {1'b0, decimation}) begin
        emit       = 1'b1;
        phase_next = '0;
      end else begin
        phase_next = phase_inc[DECIM_W-1:0];
      end
    end else if (fill_base < CNT_W'(MAX_TAPS)) begin
      fill_next = fill_inc;
    end
  end

  assign go = emit & (decimation != '0);

  // ring position step reaches the oldest used sample when step + taps wraps past MAX_TAPS
  assign tap_sum     = SUM_W'(step) + SUM_W'(taps_eff);
  assign tap_valid   = (state == S_ROTATE) && (tap_sum >= SUM_W'(MAX_TAPS));
  assign weight_addr = IDX_W'(tap_sum - SUM_W'(MAX_TAPS));

  assign ram_we = in_accept && (op == OP_COEF) && (32'(coef_index) < 32'(MAX_TAPS));

  assign mac_ctrl.clear     = sample_beat & go;
  assign mac_ctrl.tap_valid = tap_valid;
  assign mac_ctrl.scale_lo  = (state == S_SCALE_LO);
  assign mac_ctrl.scale_hi  = (state == S_SCALE_HI);
  assign mac_ctrl.combine   = (state == S_SUM);

  fdf_ram #(
    .WIDTH (COEF_BITS),
    .DEPTH (MAX_TAPS)
  ) u_tap_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(coef_index)),
    .wdata (coef_value),
    .raddr (weight_addr),
    .rdata (weight_raw)
  );

  fdf_sample_chain u_chain (
    .clk    (clk),
    .insert (sample_beat),
    .rotate (state == S_ROTATE),
    .din    (sample_value),
    .head   (ring_head)
  );

  fdf_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .sample (ring_head),
    .weight ($signed(weight_raw)),
    .scale  (scale_factor),
    .scaled (scaled)
  );

  // floor shift by 32, clip to signed 32 bits
  assign top_bits  = scaled[SCALED_W-1:SHIFT_BITS+OUT_BITS-1];
  assign sat_now   = !((&top_bits) || (~|top_bits));
  assign value_now = sat_now ? (scaled[SCALED_W-1] ? OUT_MIN : OUT_MAX)
                             : scaled[SHIFT_BITS+OUT_BITS-1:SHIFT_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= '0;
      fill_count <= '0;
      phase      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample_beat) begin
            fill_count <= fill_next;
            phase      <= phase_next;
            if (go) begin
              step  <= '0;
              state <= S_ROTATE;
            end
          end
        end
        S_ROTATE: begin
          if (step == IDX_W'(MAX_TAPS - 1)) begin
            step  <= '0;
            state <= S_FLUSH1;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_FLUSH1:   state <= S_FLUSH2;
        S_FLUSH2:   state <= S_SCALE_LO;
        S_SCALE_LO: state <= S_SCALE_HI;
        S_SCALE_HI: state <= S_SUM;
        S_SUM:      state <= S_DONE;
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            filtered_value <= value_now;
            saturated      <= sat_now;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decimation   <= DECIM_RESET;
      tap_count    <= TAPS_RESET;
      scale_factor <= SCALE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_DECIMATION: decimation   <= pwdata[DECIM_W-1:0];
        REG_TAP_COUNT:  tap_count    <= pwdata[TAP_COUNT_W-1:0];
        REG_SCALE:      scale_factor <= pwdata[SCALE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DECIMATION: prdata = APB_DATA_W'(decimation);
      REG_TAP_COUNT:  prdata = APB_DATA_W'(tap_count);
      REG_SCALE:      prdata = APB_DATA_W'(unsigned'(scale_factor));
      default:        prdata = '0;
    endcase
  end

  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_ROTATE) |-> (step == '0))
    else $error("ring step counter not parked outside rotation");

  a_rotate_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROTATE && step == IDX_W'(MAX_TAPS - 1)) |=> (state == S_FLUSH1))
    else $error("ring rotation did not end after a full turn");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(MAX_TAPS))
    else $error("fill count beyond tap store depth");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |->
      (filtered_value == $signed(OUT_MAX) || filtered_value == $signed(OUT_MIN)))
    else $error("clipped result not at a limit");

endmodule

// ===== hw/rtl/fdf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/fdf_ring_cell.sv =====
// One sample cell of the history ring: loads its neighbor's sample when enabled.
module fdf_ring_cell import fdf_pkg::*; (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [SAMPLE_BITS-1:0] d,
  output logic signed [SAMPLE_BITS-1:0] q
);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= d;
    end
  end

endmodule

// ===== hw/rtl/fdf_sample_chain.sv =====
// Sample history as a ring of cells: shifts in new samples, rotates to feed the MAC.
module fdf_sample_chain import fdf_pkg::*; (
  input  logic                          clk,
  input  logic                          insert,
  input  logic                          rotate,
  input  logic signed [SAMPLE_BITS-1:0] din,
  output logic signed [SAMPLE_BITS-1:0] head
);

  logic signed [SAMPLE_BITS-1:0] q [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] d [MAX_TAPS];
  logic                          en;

  assign en   = insert | rotate;
  assign head = q[MAX_TAPS-1];

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign d[k] = rotate ? q[MAX_TAPS-1] : din;
    end else begin : g_rest
      assign d[k] = q[k-1];
    end

    fdf_ring_cell u_cell (
      .clk (clk),
      .en  (en),
      .d   (d[k]),
      .q   (q[k])
    );
  end

endmodule

// ===== hw/rtl/fdf_mac.sv =====
// Multiply-accumulate pipeline and two-pass scale multiply of the filter sum.
module fdf_mac import fdf_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  fdf_mac_ctrl_t                 ctrl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [COEF_BITS-1:0]   weight,
  input  logic signed [SCALE_BITS-1:0]  scale,
  output logic signed [SCALED_W-1:0]    scaled
);

  logic                          v1;
  logic                          v2;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc;
  logic signed [PP_W-1:0]        pp;
  logic signed [PP_W-1:0]        pp_lo;

  logic signed [ACC_HI_W-1:0]    acc_hi;
  logic signed [MUL_A_W-1:0]     mul_a;
  logic signed [SCALED_W-1:0]    hi_ext;
  logic signed [SCALED_W-1:0]    lo_ext;

  assign acc_hi = acc[ACC_W-1:ACC_LO_W];
  assign mul_a  = ctrl.scale_hi ? MUL_A_W'(acc_hi) : $signed({1'b0, acc[ACC_LO_W-1:0]});
  assign hi_ext = SCALED_W'(pp) <<< ACC_LO_W;
  assign lo_ext = SCALED_W'(pp_lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= ctrl.tap_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    sample_q <= sample;
    if (v1) begin
      prod <= sample_q * weight;
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_W'(prod);
    end
    if (ctrl.scale_lo || ctrl.scale_hi) begin
      pp <= mul_a * scale;
    end
    if (ctrl.scale_hi) begin
      pp_lo <= pp;
    end
    if (ctrl.combine) begin
      scaled <= hi_ext + lo_ext;
    end
  end

endmodule
